/* src/sjf_pkg.sv */
// Package: shared types and constants of the shortest-job-first scheduler.
package sjf_pkg;

   localparam int TableDepth = 16;
   localparam int MaxCpus    = 8;
   localparam int IdxW       = $clog2(TableDepth);
   localparam int CntW       = $clog2(TableDepth + 1);

   localparam logic [1:0] StatusAccepted = 2'd0;
   localparam logic [1:0] StatusFull     = 2'd1;
   localparam logic [1:0] StatusSlot     = 2'd2;

   localparam logic ReqAdd  = 1'b0;
   localparam logic ReqTick = 1'b1;

   typedef struct packed {
      logic [7:0]  user;
      logic [7:0]  job;
      logic [15:0] arrival;
      logic [15:0] remaining;
      logic [15:0] order;
   } entry_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [2:0]  cpu_index;
      logic        busy_res;
      logic [7:0]  ran_job;
      logic        job_done;
      logic [7:0]  owner;
      logic [15:0] finish_time;
      logic [15:0] tick_time;
      logic        last;
   } result_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WAIT,
      ST_UPDATE,
      ST_EMIT
   } state_type;

   // true if candidate a ranks ahead of b: shorter remaining, then earlier arrival, then lower submission order
   function automatic logic ranks_ahead(entry_type a, entry_type b);
      logic r;
      if (a.remaining != b.remaining) begin
         r = a.remaining < b.remaining;
      end else if (a.arrival != b.arrival) begin
         r = a.arrival < b.arrival;
      end else begin
         r = a.order < b.order;
      end
      return r;
   endfunction

endpackage

/* src/sjf_table.sv */
// Job table memory: one synchronous write port, one registered read port.
module sjf_table
   import sjf_pkg::*;
(
   input  logic            clock,
   input  logic            wr_en,
   input  logic [IdxW-1:0] wr_addr,
   input  entry_type       wr_data,
   input  logic [IdxW-1:0] rd_addr,
   output entry_type       rd_data
);

   entry_type mem [TableDepth];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/sjf_multi_cpu_tick_scheduler_top.sv */
// Top level: shortest-job-first job table dispatching to several CPUs per tick.
//
// Input words on req_* carry either an add (req_type 0) or a tick (req_type 1).
// An add finds the lowest free entry from the valid bits, writes the job to
// the table memory and returns one word: accepted or table full. rsp_tvalid
// rises in the cycle after acceptance.
// A tick advances time, then for each CPU slot scans all table entries
// through the one registered memory read port (one entry a cycle), picks
// the shortest eligible unpicked job, decrements or retires it with a
// read-modify-write, and returns one slot report.
// The table read port and the per-slot scan set the length of a tick.
// The csr_* channel sets num_cpus (0 acts as 1, above 8 acts as 8); write it
// only while idle.
// Reset clears valid bits, time, submission count and num_cpus to 1; the
// table contents need no clearing. A stalled rsp_tready holds the result
// register and the sequencer; no new input word is taken until the current
// one has delivered all results.
module sjf_multi_cpu_tick_scheduler_top
   import sjf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // user_id, job_id, arrival_time, duration
   input  logic        req_tuser,  // req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,  // status, cpu_index, busy_res, ran_job, job_done,
                                   // owner, finish_time, tick_time, zero pad
   output logic        rsp_tlast,  // last
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_data    // num_cpus
);

   state_type        state_ff, state_in;
   logic [TableDepth-1:0] valid_ff, valid_in;
   logic [TableDepth-1:0] picked_ff, picked_in;
   logic [15:0]      time_ff, time_in;
   logic [15:0]      submit_ff, submit_in;
   logic [3:0]       ncpu_ff;
   logic [3:0]       cpu_ff, cpu_in;
   logic [3:0]       ncount_ff, ncount_in;
   logic [CntW-1:0]  scan_ff, scan_in;
   logic [IdxW-1:0]  cand_ff, cand_in;
   logic             cand_ok_ff, cand_ok_in;
   logic [IdxW-1:0]  best_ff, best_in;
   logic             best_ok_ff, best_ok_in;
   entry_type        best_e_ff, best_e_in;
   result_type       res_ff, res_in;
   logic             rvalid_ff, rvalid_in;

   logic             wr_en;
   logic [IdxW-1:0]  wr_addr;
   entry_type        wr_data;
   logic [IdxW-1:0]  rd_addr;
   entry_type        rd_data;

   logic             req_fire;
   logic [IdxW-1:0]  free_idx;
   logic             free_ok;
   logic [15:0]      dur;
   logic [3:0]       ncpu_eff;
   logic             elig;

   sjf_table u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == ST_IDLE) && !rvalid_ff;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata  = {9'b0, res_ff.tick_time, res_ff.finish_time, res_ff.owner,
                        res_ff.job_done, res_ff.ran_job, res_ff.busy_res,
                        res_ff.cpu_index, res_ff.status};
   assign rsp_tlast  = res_ff.last;
   assign dur        = req_tdata[47:32];

   always_comb begin
      free_idx = '0;
      free_ok  = 1'b0;
      for (int i = TableDepth - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_idx = IdxW'(i);
            free_ok  = 1'b1;
         end
      end
   end

   always_comb begin
      if (ncpu_ff == 4'd0) begin
         ncpu_eff = 4'd1;
      end else if (ncpu_ff > 4'(MaxCpus)) begin
         ncpu_eff = 4'(MaxCpus);
      end else begin
         ncpu_eff = ncpu_ff;
      end
   end

   assign elig = cand_ok_ff && valid_ff[cand_ff] && !picked_ff[cand_ff]
                 && (rd_data.arrival <= time_ff);

   always_comb begin
      state_in   = state_ff;
      valid_in   = valid_ff;
      picked_in  = picked_ff;
      time_in    = time_ff;
      submit_in  = submit_ff;
      cpu_in     = cpu_ff;
      ncount_in  = ncount_ff;
      scan_in    = scan_ff;
      cand_in    = cand_ff;
      cand_ok_in = 1'b0;
      best_in    = best_ff;
      best_ok_in = best_ok_ff;
      best_e_in  = best_e_ff;
      res_in     = res_ff;
      rvalid_in  = rvalid_ff;
      wr_en      = 1'b0;
      wr_addr    = free_idx;
      wr_data    = '0;
      rd_addr    = scan_ff[IdxW-1:0];

      if (rvalid_ff && rsp_tready) begin
         rvalid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_tuser == ReqAdd) begin
                  res_in    = '0;
                  res_in.last = 1'b1;
                  rvalid_in = 1'b1;
                  if (free_ok) begin
                     wr_en             = 1'b1;
                     wr_data.user      = req_tdata[7:0];
                     wr_data.job       = req_tdata[15:8];
                     wr_data.arrival   = req_tdata[31:16];
                     wr_data.remaining = (dur == 16'd0) ? 16'd1 : dur;
                     wr_data.order     = submit_ff;
                     valid_in[free_idx] = 1'b1;
                     if (submit_ff != 16'hFFFF) begin
                        submit_in = submit_ff + 16'd1;
                     end
                     res_in.status = StatusAccepted;
                  end else begin
                     res_in.status = StatusFull;
                  end
               end else begin
                  if (time_ff != 16'hFFFF) begin
                     time_in = time_ff + 16'd1;
                  end
                  picked_in  = '0;
                  cpu_in     = '0;
                  ncount_in  = ncpu_eff;
                  scan_in    = '0;
                  best_ok_in = 1'b0;
                  state_in   = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // issue read of scan entry, evaluate previous one
            cand_in    = scan_ff[IdxW-1:0];
            cand_ok_in = 1'b1;
            if (elig && (!best_ok_ff || ranks_ahead(rd_data, best_e_ff))) begin
               best_in    = cand_ff;
               best_ok_in = 1'b1;
               best_e_in  = rd_data;
            end
            if (scan_ff == CntW'(TableDepth - 1)) begin
               state_in = ST_WAIT;
            end else begin
               scan_in = scan_ff + CntW'(1);
            end
         end
         ST_WAIT: begin
            if (elig && (!best_ok_ff || ranks_ahead(rd_data, best_e_ff))) begin
               best_in    = cand_ff;
               best_ok_in = 1'b1;
               best_e_in  = rd_data;
            end
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            // hold until the previous word has left the result register
            if (!rvalid_ff) begin
               res_in             = '0;
               res_in.status      = StatusSlot;
               res_in.cpu_index   = cpu_ff[2:0];
               res_in.tick_time   = time_ff;
               res_in.last        = (cpu_ff + 4'd1 == ncount_ff);
               if (best_ok_ff) begin
                  picked_in[best_ff] = 1'b1;
                  res_in.busy_res    = 1'b1;
                  res_in.ran_job     = best_e_ff.job;
                  res_in.owner       = best_e_ff.user;
                  wr_en              = 1'b1;
                  wr_addr            = best_ff;
                  wr_data            = best_e_ff;
                  if (best_e_ff.remaining <= 16'd1) begin
                     wr_data.remaining  = '0;
                     valid_in[best_ff]  = 1'b0;
                     res_in.job_done    = 1'b1;
                     res_in.finish_time = (time_ff != 16'hFFFF) ? time_ff + 16'd1 : 16'hFFFF;
                  end else begin
                     wr_data.remaining = best_e_ff.remaining - 16'd1;
                  end
               end
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rvalid_ff) begin
               rvalid_in = 1'b1;
               if (res_ff.last) begin
                  state_in = ST_IDLE;
               end else begin
                  cpu_in     = cpu_ff + 4'd1;
                  scan_in    = '0;
                  best_ok_in = 1'b0;
                  state_in   = ST_SCAN;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         valid_ff   <= '0;
         picked_ff  <= '0;
         time_ff    <= '0;
         submit_ff  <= '0;
         ncpu_ff    <= 4'd1;
         cpu_ff     <= '0;
         ncount_ff  <= 4'd1;
         scan_ff    <= '0;
         cand_ok_ff <= 1'b0;
         best_ok_ff <= 1'b0;
         rvalid_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         valid_ff   <= valid_in;
         picked_ff  <= picked_in;
         time_ff    <= time_in;
         submit_ff  <= submit_in;
         cpu_ff     <= cpu_in;
         ncount_ff  <= ncount_in;
         scan_ff    <= scan_in;
         cand_ok_ff <= cand_ok_in;
         best_ok_ff <= best_ok_in;
         rvalid_ff  <= rvalid_in;
         if (csr_valid && csr_ready) begin
            ncpu_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      cand_ff   <= cand_in;
      best_ff   <= best_in;
      best_e_ff <= best_e_in;
      res_ff    <= res_in;
   end

   a_emit_slot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE && !rvalid_ff) |=> (state_ff == ST_EMIT))
      else $error("update not followed by emit");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_tready)
      else $error("input taken mid-tick");
   a_best_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE && best_ok_ff) |-> valid_ff[best_ff] && !picked_ff[best_ff])
      else $error("picked entry not available");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rvalid_ff && !rsp_tready) |=> rvalid_ff && $stable(res_ff))
      else $error("result dropped under stall");

endmodule
